>>> hw/rtl/rma_pkg.sv
// Shared types and constants for the rounded moving average core.
package rma_pkg;

    localparam int CFG_WIDTH = 3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_CALC,
        ST_DIV,
        ST_DONE
    } rma_state_t;

    typedef struct packed {
        logic capture;
        logic read;
        logic update;
        logic calc;
        logic div_step;
        logic load_out;
    } rma_cmd_t;

    typedef struct packed {
        logic full;
        logic div_last;
        logic out_valid;
    } rma_sts_t;

endpackage

>>> hw/rtl/rounded_moving_average_core.sv
// One sample is in flight at a time: in_stall is high from accept until the
// result is loaded, and the next sample is taken in the cycle after. While the
// window fills, the restoring divider gives one quotient bit per cycle; a full
// window skips the divider. Reset (async, active low) empties the window and
// sets window_bits to MAX_WINDOW_BITS; a window_bits write empties it as well.
module rounded_moving_average_core #(
    parameter int MAX_WINDOW_BITS = 6,
    parameter int SAMPLE_WIDTH    = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [SAMPLE_WIDTH-1:0]       sample,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [SAMPLE_WIDTH-1:0]       average,
    output logic                          window_full,
    input  logic                          cfg_wr_en,
    input  logic [rma_pkg::CFG_WIDTH-1:0] cfg_wr_data
);

    rma_pkg::rma_cmd_t cmd;
    rma_pkg::rma_sts_t sts;

    rma_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    rma_datapath #(
        .MAX_WINDOW_BITS (MAX_WINDOW_BITS),
        .SAMPLE_WIDTH    (SAMPLE_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .sample      (sample),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_stall   (out_stall),
        .average     (average),
        .window_full (window_full)
    );

    assign out_valid = sts.out_valid;

endmodule

>>> hw/rtl/rma_datapath.sv
// Datapath: sample window memory, running total, rounding divider and output register.
module rma_datapath #(
    parameter int MAX_WINDOW_BITS = 6,
    parameter int SAMPLE_WIDTH    = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rma_pkg::rma_cmd_t               cmd,
    output rma_pkg::rma_sts_t               sts,
    input  logic [SAMPLE_WIDTH-1:0]         sample,
    input  logic                            cfg_wr_en,
    input  logic [rma_pkg::CFG_WIDTH-1:0]   cfg_wr_data,
    input  logic                            out_stall,
    output logic [SAMPLE_WIDTH-1:0]         average,
    output logic                            window_full
);

    localparam int MW    = MAX_WINDOW_BITS;
    localparam int SW    = SAMPLE_WIDTH;
    localparam int TW    = SW + MW;
    localparam int NW    = TW + 1;
    localparam int DW    = MW + 2;
    localparam int WBW   = $clog2(MW + 1);
    localparam int CW    = $clog2(SW);
    localparam int DEPTH = 1 << MW;

    logic [SW-1:0]  mem [DEPTH];
    logic [SW-1:0]  sample_reg;
    logic [SW-1:0]  rd_reg;
    logic [TW-1:0]  total_reg;
    logic [TW-1:0]  total_next;
    logic [MW-1:0]  pos_reg;
    logic [MW-1:0]  pos_next;
    logic [MW:0]    fill_reg;
    logic [MW:0]    fill_next;
    logic [WBW-1:0] wbits_reg;
    logic [WBW-1:0] wbits_next;
    logic [DW-1:0]  rem_reg;
    logic [DW-1:0]  rem_next;
    logic [DW-1:0]  d_reg;
    logic [SW-1:0]  quo_reg;
    logic [SW-1:0]  quo_next;
    logic [CW-1:0]  cnt_reg;
    logic [SW-1:0]  avg_reg;
    logic           full_out_reg;
    logic           out_valid_reg;

    logic [MW:0]    size;
    logic [MW-1:0]  mask;
    logic           full;
    logic [SW-1:0]  old_sample;
    logic [TW-1:0]  shifted;
    logic [TW:0]    rounded;
    logic [NW-1:0]  num;
    logic [DW:0]    trial;
    logic [DW:0]    diff;
    logic           ge;
    logic [31:0]    cfg_ext;

    assign size = (MW + 1)'(1) << wbits_reg;
    assign mask = MW'(size - (MW + 1)'(1));
    assign full = (fill_reg == size);

    // Entries past the fill count were never written since the last clear: their old sample is taken as zero.
    assign old_sample = full ? rd_reg : '0;
    assign total_next = total_reg - TW'(old_sample) + TW'(sample_reg);
    assign pos_next   = (pos_reg + MW'(1)) & mask;
    assign fill_next  = full ? fill_reg : fill_reg + (MW + 1)'(1);

    // Full window: total / 2^bits rounded half up
    assign shifted = total_reg >> (wbits_reg - WBW'(1));
    assign rounded = (TW + 1)'(shifted) + (TW + 1)'(1);

    // Filling: (2*total + count) / (2*count), one quotient bit per cycle
    assign num   = {total_reg, 1'b0} + NW'(fill_reg);
    assign trial = {rem_reg, quo_reg[SW-1]};
    assign diff  = trial - {1'b0, d_reg};
    assign ge    = (trial >= {1'b0, d_reg});

    always_comb
    begin
        cfg_ext = 32'(cfg_wr_data);
        if (cfg_ext == 32'd0)
        begin
            wbits_next = WBW'(1);
        end
        else if (cfg_ext > 32'(MW))
        begin
            wbits_next = WBW'(MW);
        end
        else
        begin
            wbits_next = WBW'(cfg_ext);
        end
    end

    always_comb
    begin
        if (cmd.calc)
        begin
            rem_next = DW'(num[NW-1:SW]);
            quo_next = full ? rounded[SW:1] : num[SW-1:0];
        end
        else
        begin
            rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
            quo_next = {quo_reg[SW-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            mem[pos_reg] <= sample_reg;
        end
        if (cmd.read)
        begin
            rd_reg <= mem[pos_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= sample;
        end
        if (cmd.calc)
        begin
            d_reg <= DW'({fill_reg, 1'b0});
        end
        if (cmd.calc || cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        if (cmd.load_out)
        begin
            avg_reg      <= quo_reg;
            full_out_reg <= full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wbits_reg     <= WBW'(MW);
            total_reg     <= '0;
            pos_reg       <= '0;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                wbits_reg <= wbits_next;
                total_reg <= '0;
                pos_reg   <= '0;
                fill_reg  <= '0;
            end
            else if (cmd.update)
            begin
                total_reg <= total_next;
                pos_reg   <= pos_next;
                fill_reg  <= fill_next;
            end

            if (cmd.calc)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.full      = full;
    assign sts.div_last  = (cnt_reg == CW'(SW - 1));
    assign sts.out_valid = out_valid_reg;

    assign average     = avg_reg;
    assign window_full = full_out_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= size)
        else $error("fill count exceeds window length");

    // Until the window wraps, the write position tracks the fill count
    a_pos_tracks_fill: assert property (@(posedge clk) disable iff (!rst_n)
        !full |-> (fill_reg == {1'b0, pos_reg}))
        else $error("write position out of step with fill count");

    a_div_init: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.calc && !full) |=> (rem_reg < d_reg))
        else $error("divider partial remainder not below divisor");

endmodule

>>> hw/rtl/rma_ctrl.sv
// Controller: sequences read, update, rounding and output load for each transaction.
module rma_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              out_stall,
    input  rma_pkg::rma_sts_t sts,
    output rma_pkg::rma_cmd_t cmd
);

    rma_pkg::rma_state_t state_reg;
    rma_pkg::rma_state_t state_next;
    logic                out_free;

    assign out_free = !sts.out_valid || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rma_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rma_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rma_pkg::ST_READ;
                end
            end
            rma_pkg::ST_READ:
            begin
                state_next = rma_pkg::ST_UPDATE;
            end
            rma_pkg::ST_UPDATE:
            begin
                state_next = rma_pkg::ST_CALC;
            end
            rma_pkg::ST_CALC:
            begin
                state_next = sts.full ? rma_pkg::ST_DONE : rma_pkg::ST_DIV;
            end
            rma_pkg::ST_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = rma_pkg::ST_DONE;
                end
            end
            rma_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = rma_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rma_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            rma_pkg::ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            rma_pkg::ST_READ:
            begin
                cmd.read = 1'b1;
            end
            rma_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            rma_pkg::ST_CALC:
            begin
                cmd.calc = 1'b1;
            end
            rma_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            rma_pkg::ST_DONE:
            begin
                cmd.load_out = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for rounded_moving_average_core: queue-fed driver, scoreboard monitor.
module tb;

    localparam int SW          = 10;
    localparam int MWB         = 6;
    localparam int TOTW        = SW + MWB;
    localparam int CFGW        = rma_pkg::CFG_WIDTH;
    localparam int DEPTH       = 1 << MWB;
    localparam int SETTLE      = 20;
    localparam int ITEM_TARGET = 1350;

    typedef struct packed {
        logic [SW-1:0] average;
        logic          window_full;
    } mean_result_t;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_stall;
    logic [SW-1:0]        sample      = '0;
    logic                 out_valid;
    logic                 out_stall   = 1'b0;
    logic [SW-1:0]        average;
    logic                 window_full;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFGW-1:0]      cfg_wr_data = '0;

    rounded_moving_average_core #(
        .MAX_WINDOW_BITS(MWB),
        .SAMPLE_WIDTH   (SW)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .average    (average),
        .window_full(window_full),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Mirror of the averaging window
    logic [SW-1:0]     win_mem [DEPTH];
    logic [TOTW-1:0]   win_sum;
    logic [MWB-1:0]    win_pos;
    logic [MWB:0]      win_fill;
    int unsigned       win_log2;

    logic [SW-1:0] sample_backlog [$];
    mean_result_t  pending_means [$];
    mean_result_t  want;
    int            fail_cnt    = 0;
    bit            in_idle_on  = 1'b1;
    bit            out_idle_on = 1'b1;
    int            in_wait;
    int            out_wait;

    function automatic void clear_window_model();
        for (int i = 0; i < DEPTH; i++)
            win_mem[i] = '0;
        win_sum  = '0;
        win_pos  = '0;
        win_fill = '0;
    endfunction

    function automatic void apply_window_bits(input logic [CFGW-1:0] v);
        int unsigned b;
        b = 32'(v);
        if (b < 1)
            b = 1;
        if (b > MWB)
            b = MWB;
        win_log2 = b;
        clear_window_model();
    endfunction

    function automatic mean_result_t predict_mean(input logic [SW-1:0] s);
        int unsigned  size;
        int unsigned  idx;
        int unsigned  tot;
        int unsigned  cnt;
        mean_result_t r;
        size = 1 << win_log2;
        idx = 32'(win_pos) & (size - 1);
        win_sum = win_sum - TOTW'(win_mem[idx]) + TOTW'(s);
        win_mem[idx] = s;
        win_pos = MWB'((idx + 1) & (size - 1));
        if (32'(win_fill) < size)
            win_fill = win_fill + (MWB + 1)'(1);
        tot = 32'(win_sum);
        cnt = 32'(win_fill);
        r.window_full = (cnt == size);
        // half-up rounding: shift form when full, exact division while filling
        if (r.window_full)
            r.average = SW'(((tot >> (win_log2 - 1)) + 1) >> 1);
        else
            r.average = SW'((2 * tot + cnt) / (2 * cnt));
        return r;
    endfunction

    // Input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            sample   <= '0;
            in_wait = 0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (in_valid)
                pending_means.push_back(predict_mean(sample));
            if (in_wait > 0)
            begin
                in_valid <= 1'b0;
                in_wait = in_wait - 1;
            end
            else if (sample_backlog.size() > 0)
            begin
                sample   <= sample_backlog.pop_front();
                in_valid <= 1'b1;
                in_wait = in_idle_on ? $urandom_range(0, 15) : 0;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result monitor; stall count applies to the next result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_wait = 0;
        end
        else if (out_valid && !out_stall)
        begin
            if (pending_means.size() == 0)
            begin
                $error("unexpected transaction: average %0d window_full %0d",
                       average, window_full);
                fail_cnt++;
            end
            else
            begin
                want = pending_means.pop_front();
                if (average !== want.average)
                begin
                    $error("average: expected %0d, actual %0d", want.average, average);
                    fail_cnt++;
                end
                if (window_full !== want.window_full)
                begin
                    $error("window_full: expected %0d, actual %0d",
                           want.window_full, window_full);
                    fail_cnt++;
                end
            end
            out_wait = out_idle_on ? $urandom_range(0, 15) : 0;
            out_stall <= (out_wait != 0);
        end
        else if (out_valid)
        begin
            out_wait = out_wait - 1;
            out_stall <= (out_wait != 0);
        end
    end

    task automatic wait_drained();
        do
            @(negedge clk);
        while (sample_backlog.size() != 0 || in_valid || pending_means.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_window(input logic [CFGW-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        apply_window_bits(v);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        int unsigned   sent;
        int unsigned   n;
        int unsigned   mode;
        int            base;
        int            t;
        int            phase;
        logic [SW-1:0] s;

        win_log2 = MWB;
        clear_window_model();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);

        // Reset window size: extremes and alternating bit patterns
        sample_backlog = '{10'd0, 10'd1023, 10'd512, 10'd1, 10'd1022, 10'h155, 10'h2AA};
        wait_drained();

        // Zero saturates to a two-sample window; position wraps every other sample
        write_window(3'd0);
        sample_backlog = '{10'd1023, 10'd1023, 10'd0, 10'd1, 10'd1023, 10'd0};
        wait_drained();

        // Above range saturates to the largest window
        write_window(3'd7);
        sample_backlog = '{10'd1023, 10'd0, 10'd1023};
        wait_drained();

        // Four-sample window: half-way rounding, then full-scale window
        write_window(3'd2);
        sample_backlog = '{10'd1, 10'd2, 10'd1, 10'd2,
                           10'd1023, 10'd1023, 10'd1023, 10'd1023};
        wait_drained();

        sent  = 0;
        phase = 0;
        while (sent < ITEM_TARGET)
        begin
            write_window(CFGW'($urandom_range(0, 7)));
            if (phase == 1)
            begin
                in_idle_on  = 1'b0;
                out_idle_on = 1'b0;
            end
            else
            begin
                in_idle_on  = ($urandom_range(0, 3) != 0);
                out_idle_on = ($urandom_range(0, 3) != 0);
            end
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(130, 200)
                                            : $urandom_range(10, 90);
            mode = $urandom_range(0, 3);
            base = $urandom_range(0, 1023);
            for (int i = 0; i < n; i++)
            begin
                case (mode)
                    0: s = SW'($urandom_range(0, 1023));
                    1: s = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
                    2:
                    begin
                        t = base + $urandom_range(0, 6) - 3;
                        if (t < 0)
                            t = 0;
                        if (t > 1023)
                            t = 1023;
                        s = SW'(t);
                    end
                    default: s = $urandom_range(0, 1) ? 10'd1023
                                                      : SW'(1023 - $urandom_range(0, 3));
                endcase
                sample_backlog.push_back(s);
            end
            sent += n;
            phase++;
            wait_drained();
        end

        if (fail_cnt == 0 && pending_means.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/rma_pkg.sv
hw/rtl/rma_datapath.sv
hw/rtl/rma_ctrl.sv
hw/rtl/rounded_moving_average_core.sv
tb/sv/tb.sv
